// ===== hw/rtl/skms_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Skipped message key store package
// Sizes, entry and control types and result codes shared by the cell chain
// and the top level.
// ----------------------------------------------------------------------------
package skms_pkg;

  localparam int CAPACITY  = 128;
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int GRP_SIZE  = 16;
  localparam int NUM_GRP   = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;
  localparam int KEY_W     = 256;
  localparam int CTR_W     = 32;
  localparam int SKIP_W    = 64;
  localparam int HELD_W    = 8;
  localparam int CFG_W     = 32;
  localparam int ADDR_W    = 3;

  localparam logic [CFG_W-1:0] MAX_SKIP_RESET = 32'd1000;

  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_NOT_FOUND  = 2'd1;
  localparam logic [1:0] STATUS_SKIP_LARGE = 2'd2;
  localparam logic [1:0] STATUS_FULL       = 2'd3;

  localparam logic KIND_TAKE  = 1'b0;
  localparam logic KIND_STORE = 1'b1;

  typedef struct packed {
    logic [CTR_W-1:0] ctr;
    logic [KEY_W-1:0] pk;
    logic [KEY_W-1:0] mk;
  } skms_entry_t;

  typedef struct packed {
    logic             capture;
    logic             group;
    logic             remove;
    logic             store;
    logic [IDX_W-1:0] store_idx;
  } skms_ctrl_t;

  typedef struct packed {
    logic             hit;
    logic [KEY_W-1:0] found_key;
  } skms_resp_t;

endpackage

// ===== hw/rtl/skipped_message_key_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Skipped message key store
// An ordered table of skipped message keys held in a chain of entry cells.
//
// Requests arrive on the in_ channel and are taken when in_valid is high and
// in_stall is low; each request produces exactly one result on the out_
// channel, transferred when out_valid is high and out_stall is low.
// A store request decides in the cycle after its transfer, in the MATCH state,
// and its result is loaded into the output register from the DONE state. A
// take request compares all cells in parallel, resolves the first match in
// groups of sixteen cells, then removes the entry by moving every later cell
// down one place; its result is loaded from the DONE state likewise. The block
// takes a new request only after it has loaded the previous result into the
// output register, so it never works on more than one request at a time.
// A held result stays in the output register while the receiver stalls; a
// finished request then waits in the last stage, and in_stall stays high.
// Synchronous reset empties the table and sets max_skip to 1000. The APB
// register max_skip lies at address 0 and reads back its value.
// ----------------------------------------------------------------------------
module skipped_message_key_store (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_kind,
  input  logic [31:0]                   in_ratchet_counter,
  input  logic [63:0]                   in_public_key_w0,
  input  logic [63:0]                   in_public_key_w1,
  input  logic [63:0]                   in_public_key_w2,
  input  logic [63:0]                   in_public_key_w3,
  input  logic [63:0]                   in_message_key_w0,
  input  logic [63:0]                   in_message_key_w1,
  input  logic [63:0]                   in_message_key_w2,
  input  logic [63:0]                   in_message_key_w3,
  input  logic [63:0]                   in_skip_amount,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_status,
  output logic [63:0]                   out_found_key_w0,
  output logic [63:0]                   out_found_key_w1,
  output logic [63:0]                   out_found_key_w2,
  output logic [63:0]                   out_found_key_w3,
  output logic [7:0]                    out_entries_held,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [skms_pkg::ADDR_W-1:0]   paddr,
  input  logic [skms_pkg::CFG_W-1:0]    pwdata,
  output logic [skms_pkg::CFG_W-1:0]    prdata,
  output logic                          pready
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MATCH  = 3'd1;
  localparam logic [2:0] ST_GROUP  = 3'd2;
  localparam logic [2:0] ST_SELECT = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;

  logic [2:0]                     state_r;
  logic [2:0]                     state_nxt;
  logic [skms_pkg::CNT_W-1:0]     count_r;
  logic [skms_pkg::CNT_W-1:0]     count_nxt;
  logic [skms_pkg::CFG_W-1:0]     max_skip_r;
  skms_pkg::skms_entry_t          req_r;
  logic                           req_kind_r;
  logic [skms_pkg::SKIP_W-1:0]    req_skip_r;
  logic [1:0]                     status_r;
  logic                           hit_r;
  logic                           out_valid_r;
  logic [1:0]                     out_status_r;
  logic [skms_pkg::KEY_W-1:0]     out_key_r;
  logic [skms_pkg::HELD_W-1:0]    out_held_r;
  logic                           in_fire;
  logic                           out_free;
  logic                           skip_large;
  logic                           table_full;
  skms_pkg::skms_ctrl_t           ctrl;
  skms_pkg::skms_resp_t           resp;

  assign in_stall   = (state_r != ST_IDLE);
  assign in_fire    = in_valid && !in_stall;
  assign out_free   = !out_valid_r || !out_stall;
  assign skip_large = req_skip_r > skms_pkg::SKIP_W'(max_skip_r);
  assign table_full = count_r >= skms_pkg::CNT_W'(skms_pkg::CAPACITY);

  always_comb begin
    ctrl.capture   = (state_r == ST_MATCH) && (req_kind_r == skms_pkg::KIND_TAKE);
    ctrl.group     = (state_r == ST_GROUP);
    ctrl.remove    = (state_r == ST_SELECT);
    ctrl.store     = (state_r == ST_MATCH) && (req_kind_r == skms_pkg::KIND_STORE) &&
                     !skip_large && !table_full;
    ctrl.store_idx = count_r[skms_pkg::IDX_W-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_MATCH;
        end
      end
      ST_MATCH: begin
        if (req_kind_r == skms_pkg::KIND_TAKE) begin
          state_nxt = ST_GROUP;
        end else begin
          state_nxt = ST_DONE;
          if (ctrl.store) begin
            count_nxt = count_r + skms_pkg::CNT_W'(1);
          end
        end
      end
      ST_GROUP: begin
        state_nxt = ST_SELECT;
      end
      ST_SELECT: begin
        state_nxt = ST_DONE;
        if (resp.hit) begin
          count_nxt = count_r - skms_pkg::CNT_W'(1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      max_skip_r  <= skms_pkg::MAX_SKIP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
        max_skip_r <= pwdata;
      end
      if ((state_r == ST_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r.ctr  <= in_ratchet_counter;
      req_r.pk   <= {in_public_key_w3, in_public_key_w2, in_public_key_w1, in_public_key_w0};
      req_r.mk   <= {in_message_key_w3, in_message_key_w2, in_message_key_w1,
                     in_message_key_w0};
      req_kind_r <= in_kind;
      req_skip_r <= in_skip_amount;
    end
    if ((state_r == ST_MATCH) && (req_kind_r == skms_pkg::KIND_STORE)) begin
      hit_r <= 1'b0;
      if (skip_large) begin
        status_r <= skms_pkg::STATUS_SKIP_LARGE;
      end else if (table_full) begin
        status_r <= skms_pkg::STATUS_FULL;
      end else begin
        status_r <= skms_pkg::STATUS_OK;
      end
    end
    if (state_r == ST_SELECT) begin
      hit_r    <= resp.hit;
      status_r <= resp.hit ? skms_pkg::STATUS_OK : skms_pkg::STATUS_NOT_FOUND;
    end
    if ((state_r == ST_DONE) && out_free) begin
      out_status_r <= status_r;
      out_key_r    <= hit_r ? resp.found_key : '0;
      out_held_r   <= skms_pkg::HELD_W'(count_r);
    end
  end

  skms_array u_array (
    .clk       (clk),
    .ctrl      (ctrl),
    .count     (count_r),
    .req_entry (req_r),
    .resp      (resp)
  );

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_found_key_w0 = out_key_r[63:0];
  assign out_found_key_w1 = out_key_r[127:64];
  assign out_found_key_w2 = out_key_r[191:128];
  assign out_found_key_w3 = out_key_r[255:192];
  assign out_entries_held = out_held_r;
  assign pready           = 1'b1;
  assign prdata           = (paddr[2] == 1'b0) ? max_skip_r : '0;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= skms_pkg::CNT_W'(skms_pkg::CAPACITY))
    else $error("entry count exceeds capacity");

  a_count_steady: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_MATCH && state_r != ST_SELECT) |=> $stable(count_r))
    else $error("entry count changed outside a decision cycle");

  a_key_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != skms_pkg::STATUS_OK) |-> (out_key_r == '0))
    else $error("nonzero key on a failed request");
`endif

endmodule

// ===== hw/rtl/skms_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Skipped message key store cell
// Holds one entry, compares it with the request and loads either a new entry
// or the entry of its upper neighbor when the chain closes a gap.
// ----------------------------------------------------------------------------
module skms_cell (
  input  logic                         clk,
  input  logic                         capture,
  input  logic                         occupied,
  input  logic                         store_here,
  input  logic                         shift_here,
  input  skms_pkg::skms_entry_t        req_entry,
  input  skms_pkg::skms_entry_t        next_entry,
  output skms_pkg::skms_entry_t        held_entry,
  output logic                         match
);

  skms_pkg::skms_entry_t entry_r;
  logic                  match_r;

  always_ff @(posedge clk) begin
    if (store_here) begin
      entry_r <= req_entry;
    end else if (shift_here) begin
      entry_r <= next_entry;
    end
    if (capture) begin
      match_r <= occupied && (entry_r.ctr == req_entry.ctr) && (entry_r.pk == req_entry.pk);
    end
  end

  assign held_entry = entry_r;
  assign match      = match_r;

endmodule

// ===== hw/rtl/skms_array.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Skipped message key store cell chain
// The row of entry cells with the grouped first-match search, the key
// extraction and the shift that closes the gap after a removal.
// ----------------------------------------------------------------------------
module skms_array (
  input  logic                             clk,
  input  skms_pkg::skms_ctrl_t             ctrl,
  input  logic [skms_pkg::CNT_W-1:0]       count,
  input  skms_pkg::skms_entry_t            req_entry,
  output skms_pkg::skms_resp_t             resp
);

  localparam int PAD_W = skms_pkg::NUM_GRP * skms_pkg::GRP_SIZE;

  skms_pkg::skms_entry_t          cell_entry [skms_pkg::CAPACITY];
  logic [skms_pkg::CAPACITY-1:0]  match;
  logic [PAD_W-1:0]               match_pad;
  logic [PAD_W-1:0]               sel_pad;
  logic [PAD_W-1:0]               prefix_incl;
  logic [skms_pkg::NUM_GRP-1:0]   group_any_r;
  logic [skms_pkg::NUM_GRP-1:0]   group_before;
  logic [skms_pkg::KEY_W-1:0]     grp_key_r   [skms_pkg::NUM_GRP];
  logic [skms_pkg::KEY_W-1:0]     grp_key_nxt [skms_pkg::NUM_GRP];
  logic [skms_pkg::KEY_W-1:0]     found_or;

  for (genvar i = 0; i < skms_pkg::CAPACITY; i++) begin : g_cell
    skms_pkg::skms_entry_t next_entry;
    logic                  occupied;
    logic                  store_here;
    logic                  shift_here;

    if (i < skms_pkg::CAPACITY - 1) begin : g_mid
      assign next_entry = cell_entry[i + 1];
    end else begin : g_last
      assign next_entry = cell_entry[i];
    end

    assign occupied   = skms_pkg::CNT_W'(i) < count;
    assign store_here = ctrl.store && (ctrl.store_idx == skms_pkg::IDX_W'(i));
    assign shift_here = ctrl.remove && prefix_incl[i];

    skms_cell u_cell (
      .clk        (clk),
      .capture    (ctrl.capture),
      .occupied   (occupied),
      .store_here (store_here),
      .shift_here (shift_here),
      .req_entry  (req_entry),
      .next_entry (next_entry),
      .held_entry (cell_entry[i]),
      .match      (match[i])
    );
  end

  always_comb begin
    int   idx;
    logic run;
    logic [skms_pkg::KEY_W-1:0] acc;
    match_pad = '0;
    match_pad[skms_pkg::CAPACITY-1:0] = match;
    group_before[0] = 1'b0;
    for (int g = 1; g < skms_pkg::NUM_GRP; g++) begin
      group_before[g] = group_before[g-1] | group_any_r[g-1];
    end
    for (int g = 0; g < skms_pkg::NUM_GRP; g++) begin
      run = group_before[g];
      acc = '0;
      for (int k = 0; k < skms_pkg::GRP_SIZE; k++) begin
        idx = g * skms_pkg::GRP_SIZE + k;
        sel_pad[idx] = match_pad[idx] & ~run;
        run = run | match_pad[idx];
        prefix_incl[idx] = run;
        if (idx < skms_pkg::CAPACITY) begin
          if (sel_pad[idx]) begin
            acc = acc | cell_entry[idx].mk;
          end
        end
      end
      grp_key_nxt[g] = acc;
    end
    found_or = '0;
    for (int g = 0; g < skms_pkg::NUM_GRP; g++) begin
      found_or = found_or | grp_key_r[g];
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < skms_pkg::NUM_GRP; g++) begin
      if (ctrl.group) begin
        group_any_r[g] <= |match_pad[g*skms_pkg::GRP_SIZE +: skms_pkg::GRP_SIZE];
      end
      if (ctrl.remove) begin
        grp_key_r[g] <= grp_key_nxt[g];
      end
    end
  end

  assign resp.hit       = |group_any_r;
  assign resp.found_key = found_or;

endmodule

// ===== sim/tb_skipped_message_key_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Skipped message key store testbench
// Drives store and take requests into the key table under random sender gaps
// and receiver stalls, keeps its own copy of the ordered table to predict
// every result, and compares each result transfer field by field. The
// max_skip register is rewritten between phases, with its extremes among the
// values written. Random phases swing the table between empty and full, so
// that refused stores and removals from every position are exercised.
// ----------------------------------------------------------------------------
module tb_skipped_message_key_store;

  localparam logic [skms_pkg::ADDR_W-1:0] REG_MAX_SKIP = '0;
  localparam int IDLE_LIMIT  = 4000;
  localparam int PHASE_ITEMS = 380;

  typedef struct packed {
    logic                       kind;
    logic [31:0]                ctr;
    logic [skms_pkg::KEY_W-1:0] pk;
    logic [skms_pkg::KEY_W-1:0] mk;
    logic [63:0]                skip;
  } key_request_t;

  typedef struct packed {
    logic [1:0]                 status;
    logic [skms_pkg::KEY_W-1:0] found;
    logic [7:0]                 held;
  } key_reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_status;
  logic [63:0] out_found_key_w0, out_found_key_w1, out_found_key_w2, out_found_key_w3;
  logic [7:0] out_entries_held;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [skms_pkg::ADDR_W-1:0] paddr = '0;
  logic [skms_pkg::CFG_W-1:0] pwdata = '0;
  logic [skms_pkg::CFG_W-1:0] prdata;
  logic pready;

  key_request_t cur_req = '0;
  key_request_t queued_requests[$];
  key_reply_t predicted_replies[$];
  skms_pkg::skms_entry_t stored_keys[$];
  logic [31:0] max_skip_shadow = skms_pkg::MAX_SKIP_RESET;

  logic in_fire = 1'b0;
  bit quiet = 1'b0;
  bit filling = 1'b1;
  int send_gap = 0;
  int hold_left = 0;
  int idle_cycles = 0;
  int mismatch_count = 0;

  always #6 clk = ~clk;

  skipped_message_key_store dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_kind            (cur_req.kind),
    .in_ratchet_counter (cur_req.ctr),
    .in_public_key_w0   (cur_req.pk[63:0]),
    .in_public_key_w1   (cur_req.pk[127:64]),
    .in_public_key_w2   (cur_req.pk[191:128]),
    .in_public_key_w3   (cur_req.pk[255:192]),
    .in_message_key_w0  (cur_req.mk[63:0]),
    .in_message_key_w1  (cur_req.mk[127:64]),
    .in_message_key_w2  (cur_req.mk[191:128]),
    .in_message_key_w3  (cur_req.mk[255:192]),
    .in_skip_amount     (cur_req.skip),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_found_key_w0   (out_found_key_w0),
    .out_found_key_w1   (out_found_key_w1),
    .out_found_key_w2   (out_found_key_w2),
    .out_found_key_w3   (out_found_key_w3),
    .out_entries_held   (out_entries_held),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    mismatch_count++;
    $display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
  endtask

  function automatic key_reply_t serve_request(key_request_t r);
    key_reply_t res;
    int hit;
    res.status = skms_pkg::STATUS_OK;
    res.found = '0;
    hit = -1;
    if (r.kind == skms_pkg::KIND_TAKE) begin
      res.status = skms_pkg::STATUS_NOT_FOUND;
      foreach (stored_keys[i]) begin
        if (hit < 0 && stored_keys[i].ctr == r.ctr && stored_keys[i].pk == r.pk) begin
          hit = i;
        end
      end
      if (hit >= 0) begin
        res.status = skms_pkg::STATUS_OK;
        res.found = stored_keys[hit].mk;
        stored_keys.delete(hit);
      end
    end else if (r.skip > {32'd0, max_skip_shadow}) begin
      res.status = skms_pkg::STATUS_SKIP_LARGE;
    end else if (stored_keys.size() >= skms_pkg::CAPACITY) begin
      res.status = skms_pkg::STATUS_FULL;
    end else begin
      stored_keys.push_back('{ctr: r.ctr, pk: r.pk, mk: r.mk});
    end
    res.held = 8'(stored_keys.size());
    return res;
  endfunction

  function automatic logic [skms_pkg::KEY_W-1:0] rand_key();
    return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
  endfunction

  function automatic logic [63:0] pick_skip();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return 64'd0;
      1: return {32'd0, max_skip_shadow};
      2: return {32'd0, max_skip_shadow} + 64'd1;
      3: return {$urandom, $urandom};
      4: return '1;
      default: return {32'd0, 32'($urandom_range(0, max_skip_shadow))};
    endcase
  endfunction

  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 8);
    return $urandom_range(20, 60);
  endfunction

  function automatic key_request_t make_req(logic kind, logic [31:0] ctr,
                                            logic [skms_pkg::KEY_W-1:0] pk,
                                            logic [skms_pkg::KEY_W-1:0] mk,
                                            logic [63:0] skip);
    key_request_t r;
    r.kind = kind;
    r.ctr = ctr;
    r.pk = pk;
    r.mk = mk;
    r.skip = skip;
    return r;
  endfunction

  // Takes mostly aim at held entries, some with one bit of the match key flipped;
  // a few stores repeat a held counter and public key.
  function automatic key_request_t random_request();
    key_request_t r;
    int pick;
    int bitpos;
    r = make_req(skms_pkg::KIND_STORE, $urandom, rand_key(), rand_key(), pick_skip());
    if ($urandom_range(0, 99) < (filling ? 15 : 85)) r.kind = skms_pkg::KIND_TAKE;
    if (stored_keys.size() > 0 &&
        $urandom_range(0, 99) < ((r.kind == skms_pkg::KIND_TAKE) ? 85 : 10)) begin
      pick = $urandom_range(0, stored_keys.size() - 1);
      r.ctr = stored_keys[pick].ctr;
      r.pk = stored_keys[pick].pk;
      if (r.kind == skms_pkg::KIND_TAKE && $urandom_range(0, 9) == 0) begin
        bitpos = $urandom_range(0, skms_pkg::CTR_W + skms_pkg::KEY_W - 1);
        if (bitpos < skms_pkg::CTR_W) r.ctr[bitpos] = ~r.ctr[bitpos];
        else r.pk[bitpos - skms_pkg::CTR_W] = ~r.pk[bitpos - skms_pkg::CTR_W];
      end
    end
    return r;
  endfunction

  task automatic cfg_access(input logic wr, input logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= REG_MAX_SKIP;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (!wr && prdata !== max_skip_shadow) begin
      flag_mismatch("max_skip readback", 64'(prdata), 64'(max_skip_shadow));
    end
    if (wr) max_skip_shadow = data;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic wait_drained();
    while (queued_requests.size() != 0 || in_valid || predicted_replies.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  // Request driver: a held transfer keeps its payload until it is taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (queued_requests.size() > 0) begin
        cur_req <= queued_requests.pop_front();
        in_valid <= 1'b1;
        send_gap = pick_pause();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (!quiet && $urandom_range(0, 2) == 0) hold_left = pick_pause();
    end
  end

  always @(posedge clk) begin
    in_fire <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      predicted_replies.push_back(serve_request(cur_req));
    end
  end

  always @(posedge clk) begin
    key_reply_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (predicted_replies.size() == 0) begin
        flag_mismatch("unexpected result transfer", 64'(out_status), 64'd0);
      end else begin
        want = predicted_replies.pop_front();
        if (out_status !== want.status)
          flag_mismatch("status", 64'(out_status), 64'(want.status));
        if (out_found_key_w0 !== want.found[63:0])
          flag_mismatch("found_key_w0", out_found_key_w0, want.found[63:0]);
        if (out_found_key_w1 !== want.found[127:64])
          flag_mismatch("found_key_w1", out_found_key_w1, want.found[127:64]);
        if (out_found_key_w2 !== want.found[191:128])
          flag_mismatch("found_key_w2", out_found_key_w2, want.found[191:128]);
        if (out_found_key_w3 !== want.found[255:192])
          flag_mismatch("found_key_w3", out_found_key_w3, want.found[255:192]);
        if (out_entries_held !== want.held)
          flag_mismatch("entries_held", 64'(out_entries_held), 64'(want.held));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || psel || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    logic [31:0] ctr_a;
    logic [skms_pkg::KEY_W-1:0] pk_a, mk_a, mk_b;
    key_request_t x_req, y_req, z_req;
    logic [31:0] limit_plan[5];

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, run with the reset value of max_skip.
    cfg_access(1'b0, '0);
    ctr_a = $urandom;
    pk_a = rand_key();
    mk_a = rand_key();
    mk_b = rand_key();
    x_req = make_req(skms_pkg::KIND_STORE, $urandom, rand_key(), rand_key(), 64'd1);
    y_req = make_req(skms_pkg::KIND_STORE, $urandom, rand_key(), rand_key(), 64'd2);
    z_req = make_req(skms_pkg::KIND_STORE, $urandom, rand_key(), rand_key(), 64'd3);
    queued_requests.push_back(make_req(skms_pkg::KIND_TAKE, '1, '1, '0, '0));
    queued_requests.push_back(make_req(skms_pkg::KIND_STORE, '0, '0, '0, '0));
    queued_requests.push_back(make_req(skms_pkg::KIND_STORE, '1, '1, '1, 64'd1000));
    queued_requests.push_back(make_req(skms_pkg::KIND_STORE, ctr_a, pk_a, mk_a, 64'd1001));
    queued_requests.push_back(make_req(skms_pkg::KIND_STORE, ctr_a, pk_a, mk_a, '1));
    queued_requests.push_back(make_req(skms_pkg::KIND_STORE, ctr_a, pk_a, mk_a,
                                       64'h1_0000_0000));
    queued_requests.push_back(make_req(skms_pkg::KIND_STORE, ctr_a, pk_a, mk_a, 64'd5));
    queued_requests.push_back(make_req(skms_pkg::KIND_STORE, ctr_a, pk_a, mk_b, 64'd0));
    repeat (3) queued_requests.push_back(make_req(skms_pkg::KIND_TAKE, ctr_a, pk_a, '1, '1));
    queued_requests.push_back(make_req(skms_pkg::KIND_TAKE, '1,
                                       {1'b0, {(skms_pkg::KEY_W-1){1'b1}}}, '0, '0));
    queued_requests.push_back(make_req(skms_pkg::KIND_TAKE, 32'hFFFF_FFFE, '1, '0, '0));
    queued_requests.push_back(make_req(skms_pkg::KIND_TAKE, '1, '1, '0, '0));
    queued_requests.push_back(x_req);
    queued_requests.push_back(y_req);
    queued_requests.push_back(z_req);
    y_req.kind = skms_pkg::KIND_TAKE;
    z_req.kind = skms_pkg::KIND_TAKE;
    x_req.kind = skms_pkg::KIND_TAKE;
    queued_requests.push_back(y_req);
    queued_requests.push_back(z_req);
    queued_requests.push_back(x_req);
    queued_requests.push_back(make_req(skms_pkg::KIND_TAKE, '0, '0, '1, '1));
    wait_drained();

    limit_plan[0] = 32'd0;
    limit_plan[1] = 32'hFFFF_FFFF;
    limit_plan[2] = $urandom;
    limit_plan[3] = 32'd1;
    limit_plan[4] = skms_pkg::MAX_SKIP_RESET;
    for (int phase = 0; phase < 5; phase++) begin
      cfg_access(1'b1, limit_plan[phase]);
      cfg_access(1'b0, '0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        while (queued_requests.size() >= 2) @(posedge clk);
        if (n % 50 == 0) quiet = ($urandom_range(0, 3) == 0);
        if (filling && stored_keys.size() >= skms_pkg::CAPACITY && $urandom_range(0, 15) == 0)
          filling = 1'b0;
        else if (!filling && stored_keys.size() == 0)
          filling = 1'b1;
        else if ($urandom_range(0, 199) == 0)
          filling = !filling;
        queued_requests.push_back(random_request());
      end
      wait_drained();
    end

    quiet = 1'b0;
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && predicted_replies.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
